[rtl/five_tuple_flow_classifier_core_assert.svh]
// Assertion macros used by the flow classifier core.
`ifndef FIVE_TUPLE_FLOW_CLASSIFIER_CORE_ASSERT_SVH
`define FIVE_TUPLE_FLOW_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define FTFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define FTFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ftfc_pkg.sv]
// Types and constants of the five-tuple flow classifier.
package ftfc_pkg;

    // Status codes of a result
    localparam logic [2:0] ST_NEW      = 3'd0;
    localparam logic [2:0] ST_KNOWN    = 3'd1;
    localparam logic [2:0] ST_FRAGMENT = 3'd2;
    localparam logic [2:0] ST_NOT_L4   = 3'd3;
    localparam logic [2:0] ST_SHORT    = 3'd4;
    localparam logic [2:0] ST_REVERSE  = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    // Accepted protocols and minimum payload
    localparam logic [7:0]  PROTO_TCP   = 8'd6;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] MIN_PAYLOAD = 16'd4;

    // Field widths
    localparam int FRAG_W   = 13;
    localparam int ADDR_W   = 32;
    localparam int PROTO_W  = 8;
    localparam int LEN_W    = 16;
    localparam int PORT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int FID_W    = 9;
    localparam int PID_W    = 32;

    // Request packing, lowest bit first
    localparam int FRAG_LSB  = 0;
    localparam int SRC_LSB   = FRAG_LSB + FRAG_W;
    localparam int DST_LSB   = SRC_LSB + ADDR_W;
    localparam int PROTO_LSB = DST_LSB + ADDR_W;
    localparam int LEN_LSB   = PROTO_LSB + PROTO_W;
    localparam int SPORT_LSB = LEN_LSB + LEN_W;
    localparam int DPORT_LSB = SPORT_LSB + PORT_W;
    localparam int S_DATA_W  = 136;

    // Result packing, lowest bit first
    localparam int FID_LSB  = 0;
    localparam int PID_LSB  = FID_LSB + FID_W;
    localparam int M_DATA_W = 48;

    // One stored flow key
    typedef struct packed {
        logic [ADDR_W-1:0]   src_addr;
        logic [ADDR_W-1:0]   dst_addr;
        logic [2*PORT_W-1:0] ports;
        logic [PROTO_W-1:0]  protocol;
    } ftfc_tuple_t;

endpackage

[rtl/five_tuple_flow_classifier_core.sv]
// Top level of the five-tuple flow classifier: flow table and lookup sequencer.
//
// Takes one IPv4 packet summary per request and returns one result: a status, a
// flow id and the packet index within the flow. Fragments, non-TCP/UDP packets and
// payloads under 4 bytes are rejected at once: such a request goes straight to the
// emit state, which registers the result once the output register is free, and the
// next request can be taken after that. Every other request walks the key RAM, one
// entry per cycle over all flows in use, then drains the read pipeline, decides and
// emits; the emit state waits while the output register is full. A known flow also
// passes a counter state for the read-modify-write of its packet counter in the
// counter RAM. The key RAM read port is what sets the length of the walk. One
// request is worked on at a time; a finished result waits in the output register
// while the next request is already taken. Table contents need no clearing after
// reset: only the first flows_in_use entries are ever compared.
module five_tuple_flow_classifier_core
    import ftfc_pkg::*;
#(
    parameter int MAX_FLOWS = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // fragment_offset, src_addr, dst_addr, protocol, payload_len, src_port, dst_port
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // flow_id, packet_id
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // status
    output logic [STATUS_W-1:0] m_axis_tuser
);

    localparam int AW  = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
    localparam int CW  = $clog2(MAX_FLOWS + 1);
    localparam int IDW = (CW > FID_W) ? CW : FID_W;
    localparam int TW  = $bits(ftfc_tuple_t);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_CNT    = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic                rev_reg, rev_next;
    logic                fwd_reg, fwd_next;
    logic [AW-1:0]       fwd_idx_reg, fwd_idx_next;
    logic                m_valid_reg, m_valid_next;

    logic [ADDR_W-1:0]   in_src_reg, in_dst_reg;
    logic [PROTO_W-1:0]  in_proto_reg;
    logic [PORT_W-1:0]   in_sport_reg, in_dport_reg;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [FID_W-1:0]    res_fid_reg, res_fid_next;
    logic [PID_W-1:0]    res_pid_reg, res_pid_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [FID_W-1:0]    out_fid_reg;
    logic [PID_W-1:0]    out_pid_reg;

    logic                in_fire, out_free;
    logic [FRAG_W-1:0]   req_frag;
    logic [PROTO_W-1:0]  req_proto;
    logic [LEN_W-1:0]    req_len;
    ftfc_tuple_t         fwd_key, rev_key, tup_rdata;
    logic [TW-1:0]       tup_rdata_raw;
    logic                tup_we, cnt_we;
    logic [AW-1:0]       tup_raddr, cnt_raddr, cnt_waddr;
    logic [PID_W-1:0]    cnt_wdata, cnt_rdata, cnt_inc;
    logic [IDW-1:0]      fid_fwd, fid_new;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign req_frag  = s_axis_tdata[FRAG_LSB +: FRAG_W];
    assign req_proto = s_axis_tdata[PROTO_LSB +: PROTO_W];
    assign req_len   = s_axis_tdata[LEN_LSB +: LEN_W];

    // Keys of the held request, as stored and reversed
    assign fwd_key = '{src_addr: in_src_reg, dst_addr: in_dst_reg,
                       ports: {in_sport_reg, in_dport_reg}, protocol: in_proto_reg};
    assign rev_key = '{src_addr: in_dst_reg, dst_addr: in_src_reg,
                       ports: {in_dport_reg, in_sport_reg}, protocol: in_proto_reg};
    assign tup_rdata = ftfc_tuple_t'(tup_rdata_raw);

    assign cnt_inc = cnt_rdata + PID_W'(1);
    assign fid_fwd = IDW'(fwd_idx_reg) + IDW'(1);
    assign fid_new = IDW'(used_reg) + IDW'(1);

    // Key table and packet counters
    ftfc_ram #(.WIDTH(TW), .DEPTH(MAX_FLOWS)) u_key_ram (
        .aclk    (aclk),
        .wr_en   (tup_we),
        .wr_addr (used_reg[AW-1:0]),
        .wr_data (fwd_key),
        .rd_addr (tup_raddr),
        .rd_data (tup_rdata_raw)
    );

    ftfc_ram #(.WIDTH(PID_W), .DEPTH(MAX_FLOWS)) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (cnt_waddr),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        used_next       = used_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        rev_next        = rev_reg;
        fwd_next        = fwd_reg;
        fwd_idx_next    = fwd_idx_reg;
        res_status_next = res_status_reg;
        res_fid_next    = res_fid_reg;
        res_pid_next    = res_pid_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        tup_we          = 1'b0;
        cnt_we          = 1'b0;
        tup_raddr       = issue_reg[AW-1:0];
        cnt_raddr       = fwd_idx_reg;
        cnt_waddr       = used_reg[AW-1:0];
        cnt_wdata       = '0;

        case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    res_fid_next = '0;
                    res_pid_next = '0;
                    rev_next     = 1'b0;
                    fwd_next     = 1'b0;
                    issue_next   = '0;
                    if (req_frag != '0) begin
                        res_status_next = ST_FRAGMENT;
                        state_next      = S_EMIT;
                    end else if (!(req_proto inside {PROTO_TCP, PROTO_UDP})) begin
                        res_status_next = ST_NOT_L4;
                        state_next      = S_EMIT;
                    end else if (req_len < MIN_PAYLOAD) begin
                        res_status_next = ST_SHORT;
                        state_next      = S_EMIT;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Issue one read per cycle over the entries in use
                if (issue_reg < used_reg) begin
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[AW-1:0];
                    issue_next    = issue_reg + CW'(1);
                end
                // Compare the entry read last cycle
                if (pend_reg) begin
                    if (tup_rdata == rev_key) begin
                        rev_next = 1'b1;
                    end
                    if (tup_rdata == fwd_key && !fwd_reg) begin
                        fwd_next     = 1'b1;
                        fwd_idx_next = pend_idx_reg;
                    end
                end else if (issue_reg == used_reg) begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (rev_reg) begin
                    res_status_next = ST_REVERSE;
                    state_next      = S_EMIT;
                end else if (fwd_reg) begin
                    state_next = S_CNT;
                end else if (used_reg == CW'(MAX_FLOWS)) begin
                    res_status_next = ST_FULL;
                    state_next      = S_EMIT;
                end else begin
                    // New flow takes the next free entry
                    tup_we          = 1'b1;
                    cnt_we          = 1'b1;
                    used_next       = used_reg + CW'(1);
                    res_status_next = ST_NEW;
                    res_fid_next    = fid_new[FID_W-1:0];
                    state_next      = S_EMIT;
                end
            end
            S_CNT: begin
                // Counter read data is back: bump and write it
                cnt_we          = 1'b1;
                cnt_waddr       = fwd_idx_reg;
                cnt_wdata       = cnt_inc;
                res_status_next = ST_KNOWN;
                res_fid_next    = fid_fwd[FID_W-1:0];
                res_pid_next    = cnt_inc;
                state_next      = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            issue_reg   <= '0;
            pend_reg    <= 1'b0;
            rev_reg     <= 1'b0;
            fwd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            issue_reg   <= issue_next;
            pend_reg    <= pend_next;
            rev_reg     <= rev_next;
            fwd_reg     <= fwd_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pend_idx_reg   <= pend_idx_next;
        fwd_idx_reg    <= fwd_idx_next;
        res_status_reg <= res_status_next;
        res_fid_reg    <= res_fid_next;
        res_pid_reg    <= res_pid_next;
        if (in_fire) begin
            in_src_reg   <= s_axis_tdata[SRC_LSB +: ADDR_W];
            in_dst_reg   <= s_axis_tdata[DST_LSB +: ADDR_W];
            in_proto_reg <= req_proto;
            in_sport_reg <= s_axis_tdata[SPORT_LSB +: PORT_W];
            in_dport_reg <= s_axis_tdata[DPORT_LSB +: PORT_W];
        end
        if (state_reg == S_EMIT && out_free) begin
            out_status_reg <= res_status_reg;
            out_fid_reg    <= res_fid_reg;
            out_pid_reg    <= res_pid_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(M_DATA_W - FID_W - PID_W){1'b0}}, out_pid_reg, out_fid_reg};

    `include "five_tuple_flow_classifier_core_assert.svh"

    `FTFC_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CW'(MAX_FLOWS), "flow count past table size")
    `FTFC_ASSERT_NOW(a_reject_zero,
        m_valid_reg && out_status_reg != ST_NEW && out_status_reg != ST_KNOWN,
        out_fid_reg == '0 && out_pid_reg == '0, "rejected result carries id")
    `FTFC_ASSERT_NOW(a_accept_zero_id,
        m_valid_reg && (out_status_reg == ST_NEW || out_status_reg == ST_KNOWN),
        out_fid_reg != '0 || CW > FID_W, "accepted result has zero flow id")
    `FTFC_ASSERT_NEXT(a_new_grows,
        state_reg == S_DECIDE && !rev_reg && !fwd_reg && used_reg != CW'(MAX_FLOWS),
        used_reg == $past(used_reg) + CW'(1), "new flow did not take an entry")
    `FTFC_ASSERT_NEXT(a_rev_wins, state_reg == S_DECIDE && rev_reg,
        res_status_reg == ST_REVERSE && used_reg == $past(used_reg),
        "reverse hit not reported")

endmodule

[rtl/ftfc_ram.sv]
// Generic single-port-write, registered-read RAM.
module ftfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
